### src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/cat_rff_pkg.sv
`timescale 1ns / 1ps
package cat_rff_pkg;

    localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
    localparam logic [63:0] TUNE_HOLD_US = 64'd300000;

    localparam logic [15:0] PFX_FA = 16'h4641;
    localparam logic [15:0] PFX_FB = 16'h4642;
    localparam logic [15:0] PFX_IF = 16'h4946;
    localparam logic [15:0] PFX_SM = 16'h534D;
    localparam logic [15:0] PFX_RM = 16'h524D;
    localparam logic [15:0] PFX_EX = 16'h4558;
    localparam logic [15:0] PFX_VV = 16'h5656;
    localparam logic [15:0] PFX_SS = 16'h5353;
    localparam logic [15:0] PFX_SU = 16'h5355;
    localparam logic [15:0] PFX_TX = 16'h5458;
    localparam logic [15:0] PFX_RX = 16'h5258;

    localparam logic [2:0] RSN_FORWARD  = 3'd0;
    localparam logic [2:0] RSN_SHORT    = 3'd1;
    localparam logic [2:0] RSN_TUNING   = 3'd2;
    localparam logic [2:0] RSN_NOT_QRY  = 3'd3;
    localparam logic [2:0] RSN_DUP      = 3'd4;
    localparam logic [2:0] RSN_RATE     = 3'd5;
    localparam logic [2:0] RSN_FAIRNESS = 3'd6;

    localparam logic [2:0] CFG_AI_MODE     = 3'd0;
    localparam logic [2:0] CFG_DISPLAY     = 3'd1;
    localparam logic [2:0] CFG_SM_INT      = 3'd2;
    localparam logic [2:0] CFG_SM_INT_DISP = 3'd3;
    localparam logic [2:0] CFG_FAIR        = 3'd4;

    localparam logic [2:0] MODE_AI2 = 3'd2;
    localparam logic [2:0] MODE_AI4 = 3'd4;
    localparam logic [2:0] MODE_OFF = 3'd0;

    typedef struct packed {
        logic [15:0] prefix;
        logic [7:0]  cnt;
        logic [63:0] value;
        logic        f_semi;
        logic        f_bad;
        logic        f_ovf;
        logic        f_dig;
        logic [13:0] meter;
        logic [1:0]  sel;
        logic        meter_ok;
        logic [63:0] hash;
    } t_frame;

    typedef struct packed {
        logic [2:0]  ai_mode;
        logic        display;
        logic [23:0] sm_int;
        logic [23:0] sm_int_disp;
        logic [23:0] fair;
    } t_cfg;

    // Multiply by the FNV-64 prime, 2^40 + 0x1B3, as shifts and adds.
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

### src/cat_rff_parse.sv
`timescale 1ns / 1ps
module cat_rff_parse
    import cat_rff_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_frame     o_frame
);

    // Everything zero except the hash, which starts from the offset basis.
    localparam t_frame FRAME_CLEAR = {109'd0, FNV_BASIS};

    t_frame r_fr;
    logic   r_live;
    t_frame n_fr;
    logic   n_live;

    logic        dig;
    logic [3:0]  d;
    logic [67:0] prod;

    assign dig  = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign d    = i_byte[3:0];
    assign prod = ({4'd0, r_fr.value} << 3) + ({4'd0, r_fr.value} << 1) + {64'd0, d};

    always_comb begin
        n_fr   = r_fr;
        n_live = r_live;
        n_fr.hash = fnv_mul(r_fr.hash ^ {56'd0, i_byte});
        if (r_fr.cnt == 8'd0) begin
            n_fr.prefix = {i_byte, 8'd0};
        end else if (r_fr.cnt == 8'd1) begin
            n_fr.prefix = {r_fr.prefix[15:8], i_byte};
        end else begin
            if (!r_fr.f_semi) begin
                if (i_byte == 8'h3B) begin
                    n_fr.f_semi = 1'b1;
                end else if (dig) begin
                    n_fr.f_dig = 1'b1;
                    if (!r_fr.f_ovf) begin
                        if (|prod[67:64]) n_fr.f_ovf = 1'b1;
                        else n_fr.value = prod[63:0];
                    end
                end else begin
                    n_fr.f_bad = 1'b1;
                end
            end
            if (r_fr.cnt == 8'd2) begin
                n_fr.sel = (i_byte >= 8'h31 && i_byte <= 8'h33) ? i_byte[1:0] : 2'd0;
            end else if (r_fr.cnt == 8'd3) begin
                n_fr.meter_ok = dig;
                n_live        = dig;
                n_fr.meter    = dig ? {10'd0, d} : 14'd0;
            end else if (r_fr.cnt <= 8'd6 && r_live) begin
                if (dig) n_fr.meter = (r_fr.meter << 3) + (r_fr.meter << 1) + {10'd0, d};
                else n_live = 1'b0;
            end
        end
        if (r_fr.cnt != 8'hFF) n_fr.cnt = r_fr.cnt + 8'd1;
    end

    assign o_frame = n_fr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_end)) begin
            r_fr   <= FRAME_CLEAR;
            r_live <= 1'b0;
        end else if (i_step) begin
            r_fr   <= n_fr;
            r_live <= n_live;
        end
    end

endmodule

### src/cat_rff_decide.sv
`timescale 1ns / 1ps
module cat_rff_decide
    import cat_rff_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_commit_en,
    input  t_frame      i_frame,
    input  t_cfg        i_cfg,
    input  logic [63:0] i_now,
    input  logic        i_queried,
    input  logic        i_tuning,
    input  logic [63:0] i_enc,
    output logic [2:0]  o_reason
);

    logic [63:0] r_fa, r_fb, r_if, r_sm_time, r_fwd_time;
    logic [30:0] r_sm_lvl;
    logic [13:0] r_meter [3];
    logic        r_was_sm;

    logic fa, fb, is_if, sm, rm, ex, num_ok, sm_ok, rm_ok, ai, commit;
    logic [1:0]  midx;
    logic [63:0] lim, d_sm, d_fwd, d_enc;

    assign fa     = i_frame.prefix == PFX_FA;
    assign fb     = i_frame.prefix == PFX_FB;
    assign is_if  = i_frame.prefix == PFX_IF;
    assign sm     = i_frame.prefix == PFX_SM;
    assign rm     = i_frame.prefix == PFX_RM;
    assign ex     = i_frame.prefix == PFX_EX;
    assign num_ok = (i_frame.cnt >= 8'd4) && !i_frame.f_bad && !i_frame.f_ovf && i_frame.f_dig;
    assign sm_ok  = num_ok && (i_frame.value[63:31] == '0);
    assign rm_ok  = rm && (i_frame.cnt >= 8'd7) && (i_frame.sel != 2'd0) && i_frame.meter_ok;
    assign midx   = i_frame.sel - 2'd1;
    assign ai     = (i_cfg.ai_mode == MODE_AI2) || (i_cfg.ai_mode == MODE_AI4);
    assign lim    = {40'd0, i_cfg.display ? i_cfg.sm_int_disp : i_cfg.sm_int};
    assign d_sm   = i_now - r_sm_time;
    assign d_fwd  = i_now - r_fwd_time;
    assign d_enc  = i_now - i_enc;

    always_comb begin
        o_reason = RSN_FORWARD;
        commit   = 1'b0;
        if (i_frame.cnt < 8'd2) begin
            o_reason = RSN_SHORT;
        end else if (i_cfg.display && (is_if || fa || fb) &&
                     (i_tuning || (i_enc != 64'd0 && d_enc < TUNE_HOLD_US))) begin
            o_reason = RSN_TUNING;
        end else if (ai) begin
            if (ex) begin
                o_reason = i_queried ? RSN_FORWARD : RSN_NOT_QRY;
            end else if ((fa && num_ok && i_frame.value == r_fa) ||
                         (fb && num_ok && i_frame.value == r_fb) ||
                         (is_if && i_frame.hash == r_if) ||
                         (sm && sm_ok && i_frame.value == {33'd0, r_sm_lvl}) ||
                         (rm_ok && i_frame.meter == r_meter[midx])) begin
                o_reason = RSN_DUP;
            end else if (sm && r_sm_time != 64'd0 && d_sm < lim) begin
                o_reason = RSN_RATE;
            end else if (sm && r_fwd_time != 64'd0 && d_fwd < {40'd0, i_cfg.fair} && r_was_sm) begin
                o_reason = RSN_FAIRNESS;
            end else begin
                commit = 1'b1;
            end
        end else if (!i_queried) begin
            o_reason = RSN_NOT_QRY;
            if (i_cfg.ai_mode != MODE_OFF) begin
                case (i_frame.prefix) inside
                    PFX_VV, PFX_SS, PFX_SU, PFX_TX, PFX_RX: o_reason = RSN_FORWARD;
                    default: o_reason = RSN_NOT_QRY;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa       <= '0;
            r_fb       <= '0;
            r_if       <= '0;
            r_sm_time  <= '0;
            r_fwd_time <= '0;
            r_sm_lvl   <= '0;
            r_meter    <= '{default: '0};
            r_was_sm   <= 1'b0;
        end else if (i_commit_en && commit) begin
            r_fwd_time <= i_now;
            r_was_sm   <= sm;
            if (sm) r_sm_time <= i_now;
            if (fa && num_ok) r_fa <= i_frame.value;
            if (fb && num_ok) r_fb <= i_frame.value;
            if (is_if) r_if <= i_frame.hash;
            if (sm && sm_ok) r_sm_lvl <= i_frame.value[30:0];
            if (rm_ok) r_meter[midx] <= i_frame.meter;
        end
    end

endmodule

### src/cat_response_forward_filter_core.sv
`timescale 1ns / 1ps
// A final byte goes to the input register, its result to the result register.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two channels, and a final byte waits in the input register only
// while a previous result is still untaken.
// Reset (synchronous, active low) clears configuration, frame and history state.
`include "assert_macros.svh"
module cat_response_forward_filter_core
    import cat_rff_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_resp_byte,
    input  logic        i_frame_end,
    input  logic [63:0] i_now_us,
    input  logic        i_recently_queried,
    input  logic        i_tuning_active,
    input  logic [63:0] i_last_encoder_us,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_forward,
    output logic [2:0]  o_block_reason
);

    t_cfg        r_cfg;
    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_end;
    logic [63:0] r_s1_now;
    logic        r_s1_qry;
    logic        r_s1_tune;
    logic [63:0] r_s1_enc;
    logic        r_out_valid;
    logic        r_out_fwd;
    logic [2:0]  r_out_rsn;

    logic   consume;
    t_frame frame;
    logic [2:0] reason;

    assign o_cfg_ready = 1'b1;
    assign consume = r_s1_valid && (!r_s1_end || !r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_AI_MODE:     r_cfg.ai_mode     <= i_cfg_data[2:0];
                CFG_DISPLAY:     r_cfg.display     <= i_cfg_data[0];
                CFG_SM_INT:      r_cfg.sm_int      <= i_cfg_data;
                CFG_SM_INT_DISP: r_cfg.sm_int_disp <= i_cfg_data;
                CFG_FAIR:        r_cfg.fair        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_s1_byte <= i_resp_byte;
            r_s1_end  <= i_frame_end;
            r_s1_now  <= i_now_us;
            r_s1_qry  <= i_recently_queried;
            r_s1_tune <= i_tuning_active;
            r_s1_enc  <= i_last_encoder_us;
        end
    end

    cat_rff_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (consume),
        .i_byte  (r_s1_byte),
        .i_end   (r_s1_end),
        .o_frame (frame)
    );

    cat_rff_decide u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit_en (consume && r_s1_end),
        .i_frame     (frame),
        .i_cfg       (r_cfg),
        .i_now       (r_s1_now),
        .i_queried   (r_s1_qry),
        .i_tuning    (r_s1_tune),
        .i_enc       (r_s1_enc),
        .o_reason    (reason)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && r_s1_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (consume && r_s1_end) begin
            r_out_fwd <= (reason == RSN_FORWARD);
            r_out_rsn <= reason;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_forward      = r_out_fwd;
    assign o_block_reason = r_out_rsn;

    `ASSERT_SAME(a_fwd_matches_reason, i_clk, i_rst_n, r_out_valid, r_out_fwd == (r_out_rsn == RSN_FORWARD), "forward flag disagrees with reason")
    `ASSERT_NEXT(a_mid_byte_no_result, i_clk, i_rst_n, consume && !r_s1_end && !r_out_valid, !r_out_valid, "result from a non-final byte")
    `ASSERT_NEXT(a_final_held, i_clk, i_rst_n, r_s1_valid && r_s1_end && r_out_valid && !i_ready, r_s1_valid, "final byte lost while result stalled")

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import cat_rff_pkg::*;

    typedef struct {
        logic [7:0]  rbyte;
        logic        last;
        logic [63:0] now;
        logic        queried;
        logic        tuning;
        logic [63:0] enc;
    } byte_item_t;

    typedef struct {
        logic       fwd;
        logic [2:0] reason;
    } verdict_t;

    localparam logic [63:0] HASH_MULT = 64'd1099511628211;
    localparam int          WATCHDOG_LIMIT = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_addr;
    logic [23:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_resp_byte;
    logic        i_frame_end;
    logic [63:0] i_now_us;
    logic        i_recently_queried;
    logic        i_tuning_active;
    logic [63:0] i_last_encoder_us;
    logic        o_valid;
    logic        i_ready;
    logic        o_forward;
    logic [2:0]  o_block_reason;

    cat_response_forward_filter_core DUT (.*);

    byte_item_t pending_bytes[$];
    verdict_t   verdicts_due[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    bit         byte_taken = 0;
    int         burst_left = 8;
    int         gap_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;

    // Filter configuration as seen by the predictor.
    logic [2:0]  cfg_mode = '0;
    logic        cfg_disp = '0;
    logic [23:0] cfg_sm = '0, cfg_smd = '0, cfg_fair = '0;

    // Per-frame parse state.
    logic [15:0] cur_prefix = '0;
    logic [7:0]  cur_count = '0;
    logic [63:0] cur_value = '0;
    logic        fl_semi = 0, fl_bad = 0, fl_ovf = 0, fl_dig = 0;
    logic [15:0] meter_val = '0;
    logic [1:0]  meter_slot = '0;
    logic        meter_good = 0, meter_run = 0;
    logic [63:0] cur_hash = FNV_BASIS;

    // History of forwarded frames.
    logic [63:0] hist_fa = '0, hist_fb = '0, hist_if = '0;
    logic [31:0] hist_sm = '0;
    logic [15:0] hist_meter[3] = '{default: '0};
    logic [63:0] sm_stamp = '0, fwd_stamp = '0;
    logic        prev_sm = 0;

    logic [63:0] t_now = 64'd1000;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit is_num(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [2:0] decide_dedup(logic [63:0] now, logic queried);
        logic fa, fb, isif, sm, rm, num_ok, sm_ok, rm_ok;
        logic [63:0] lim;
        fa = cur_prefix == PFX_FA;
        fb = cur_prefix == PFX_FB;
        isif = cur_prefix == PFX_IF;
        sm = cur_prefix == PFX_SM;
        rm = cur_prefix == PFX_RM;
        num_ok = cur_count >= 4 && !fl_bad && !fl_ovf && fl_dig;
        sm_ok = num_ok && cur_value <= 64'h7FFFFFFF;
        rm_ok = rm && cur_count >= 7 && meter_slot != 0 && meter_good;
        if (cur_prefix == PFX_EX) return queried ? RSN_FORWARD : RSN_NOT_QRY;
        if ((fa || fb) && num_ok && cur_value == (fa ? hist_fa : hist_fb)) return RSN_DUP;
        if (isif && cur_hash == hist_if) return RSN_DUP;
        if (sm && sm_ok && cur_value == {32'd0, hist_sm}) return RSN_DUP;
        if (rm_ok && meter_val == hist_meter[meter_slot - 2'd1]) return RSN_DUP;
        if (sm) begin
            lim = cfg_disp ? {40'd0, cfg_smd} : {40'd0, cfg_sm};
            if (sm_stamp != 0 && (now - sm_stamp) < lim) return RSN_RATE;
            if (fwd_stamp != 0 && (now - fwd_stamp) < {40'd0, cfg_fair} && prev_sm)
                return RSN_FAIRNESS;
            sm_stamp = now;
            prev_sm = 1;
        end else begin
            prev_sm = 0;
        end
        fwd_stamp = now;
        if (fa && num_ok) hist_fa = cur_value;
        if (fb && num_ok) hist_fb = cur_value;
        if (isif) hist_if = cur_hash;
        if (sm && sm_ok) hist_sm = cur_value[31:0];
        if (rm_ok) hist_meter[meter_slot - 2'd1] = meter_val;
        return RSN_FORWARD;
    endfunction

    function automatic logic [2:0] decide_frame(byte_item_t it);
        if (cur_count < 2) return RSN_SHORT;
        if (cfg_disp && (cur_prefix == PFX_IF || cur_prefix == PFX_FA ||
                         cur_prefix == PFX_FB)) begin
            if (it.tuning || (it.enc != 0 && (it.now - it.enc) < TUNE_HOLD_US))
                return RSN_TUNING;
        end
        if (cfg_mode == MODE_AI2 || cfg_mode == MODE_AI4)
            return decide_dedup(it.now, it.queried);
        if (it.queried) return RSN_FORWARD;
        if (cfg_mode == MODE_OFF) return RSN_NOT_QRY;
        if (cur_prefix inside {PFX_VV, PFX_SS, PFX_SU, PFX_TX, PFX_RX}) return RSN_FORWARD;
        return RSN_NOT_QRY;
    endfunction

    // Advances the frame parser by one byte and queues a verdict on the final byte.
    function automatic void filter_byte(byte_item_t it);
        logic [63:0] d;
        logic [7:0] b;
        verdict_t v;
        b = it.rbyte;
        d = {56'd0, b - 8'd48};
        cur_hash = (cur_hash ^ {56'd0, b}) * HASH_MULT;
        if (cur_count == 0) begin
            cur_prefix = {b, 8'd0};
        end else if (cur_count == 1) begin
            cur_prefix[7:0] = b;
        end else begin
            if (!fl_semi) begin
                if (b == ";") begin
                    fl_semi = 1;
                end else if (is_num(b)) begin
                    fl_dig = 1;
                    if (!fl_ovf) begin
                        if (cur_value > (64'hFFFFFFFFFFFFFFFF - d) / 10) fl_ovf = 1;
                        else cur_value = cur_value * 10 + d;
                    end
                end else begin
                    fl_bad = 1;
                end
            end
            if (cur_count == 2) begin
                meter_slot = (b >= "1" && b <= "3") ? d[1:0] : 2'd0;
            end else if (cur_count == 3) begin
                meter_good = is_num(b);
                meter_run = meter_good;
                meter_val = meter_good ? d[15:0] : 16'd0;
            end else if (cur_count <= 6 && meter_run) begin
                if (is_num(b)) meter_val = meter_val * 10 + d[15:0];
                else meter_run = 0;
            end
        end
        if (cur_count != 8'd255) cur_count++;
        if (!it.last) return;
        v.reason = decide_frame(it);
        v.fwd = v.reason == RSN_FORWARD;
        verdicts_due.push_back(v);
        cur_prefix = '0;
        cur_count = '0;
        cur_value = '0;
        {fl_semi, fl_bad, fl_ovf, fl_dig} = '0;
        meter_val = '0;
        meter_slot = '0;
        meter_good = 0;
        meter_run = 0;
        cur_hash = FNV_BASIS;
    endfunction

    // Sender: bursts of items with random gaps.
    always @(negedge i_clk) begin
        byte_item_t it;
        if (!i_rst_n || (i_valid && !byte_taken)) begin
        end else if (gap_left > 0) begin
            gap_left--;
            i_valid <= 0;
        end else if (pending_bytes.size() > 0) begin
            it = pending_bytes.pop_front();
            i_valid <= 1;
            i_resp_byte <= it.rbyte;
            i_frame_end <= it.last;
            i_now_us <= it.now;
            i_recently_queried <= it.queried;
            i_tuning_active <= it.tuning;
            i_last_encoder_us <= it.enc;
            if (--burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                           ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                       : $urandom_range(1, 4);
            end
        end else begin
            i_valid <= 0;
        end
        byte_taken = 0;
        if (i_rst_n) begin
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            i_ready <= stall_pattern[0];
        end
    end

    // Result checker and input acceptance.
    always @(posedge i_clk) begin
        verdict_t want;
        byte_item_t it;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result forward=%0b reason=%0d",
                                 o_forward, o_block_reason);
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_forward !== want.fwd || o_block_reason !== want.reason) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected forward=%0b reason=%0d, ",
                                      "got forward=%0b reason=%0d"},
                                     want.fwd, want.reason, o_forward, o_block_reason);
                    end
                end
            end
            if (i_valid && o_ready) begin
                it.rbyte = i_resp_byte;
                it.last = i_frame_end;
                it.now = i_now_us;
                it.queried = i_recently_queried;
                it.tuning = i_tuning_active;
                it.enc = i_last_encoder_us;
                filter_byte(it);
                byte_taken = 1;
            end
            if ((o_valid && i_ready) || (i_valid && o_ready) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [23:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (addr)
            CFG_AI_MODE: cfg_mode = data[2:0];
            CFG_DISPLAY: cfg_disp = data[0];
            CFG_SM_INT: cfg_sm = data;
            CFG_SM_INT_DISP: cfg_smd = data;
            CFG_FAIR: cfg_fair = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // Queues one frame; the bytes before the last carry random side fields.
    task automatic queue_frame(byte unsigned fr[$]);
        byte_item_t it;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) t_now = {$urandom, $urandom};
        else if (r == 1) t_now = 64'hFFFFFFFFFFFFFFFF - $urandom_range(0, 3000);
        else if (r == 2) t_now = 0;
        else t_now += $urandom_range(0, 4000);
        foreach (fr[i]) begin
            it.rbyte = fr[i];
            it.last = (i == fr.size() - 1);
            it.queried = $urandom_range(0, 1);
            it.tuning = ($urandom_range(0, 4) == 0);
            if (it.last) begin
                it.now = t_now;
                r = $urandom_range(0, 5);
                it.enc = (r == 0) ? 64'd0 : (r == 1) ? t_now - $urandom_range(0, 299999) :
                         (r == 2) ? t_now - $urandom_range(300000, 900000) :
                         (r == 3) ? t_now + $urandom_range(1, 1000) :
                         (r == 4) ? t_now - 64'd300000 : {$urandom, $urandom};
            end else begin
                it.now = {$urandom, $urandom};
                it.enc = {$urandom, $urandom};
            end
            pending_bytes.push_back(it);
        end
    endtask

    function automatic void add_text(ref byte unsigned fr[$], input string s);
        for (int i = 0; i < s.len(); i++) fr.push_back(s[i]);
    endfunction

    function automatic void add_tail(ref byte unsigned fr[$]);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) fr.push_back(";");
        else if (r == 6) add_text(fr, $sformatf(";%0d;", $urandom_range(0, 99)));
        else if (r == 7) fr.push_back(8'($urandom_range(0, 255)));
        else if (r == 8) add_text(fr, "x;");
    endfunction

    task automatic random_frame();
        byte unsigned fr[$];
        string pfx[] = '{"VV", "SS", "SU", "TX", "RX"};
        logic [63:0] freqs[] = '{64'd14074000, 64'd7100000, 64'd3573000};
        logic [63:0] v;
        int k, n;
        k = $urandom_range(0, 19);
        if (k < 4) begin
            add_text(fr, $urandom_range(0, 1) ? "FA" : "FB");
            n = $urandom_range(0, 9);
            if (n < 6) add_text(fr, $sformatf("%011d", freqs[$urandom_range(0, 2)]));
            else if (n == 6) add_text(fr, "99999999999999999999");
            else if (n == 7) add_text(fr, "18446744073709551615");
            else if (n == 8) add_text(fr, $sformatf("%0d", $urandom));
            add_tail(fr);
        end else if (k < 6) begin
            add_text(fr, "IF");
            add_text(fr, $sformatf("000%08d0000+00000000%0d", freqs[$urandom_range(0, 1)],
                                   $urandom_range(0, 1)));
            fr.push_back(";");
        end else if (k < 9) begin
            add_text(fr, "SM0");
            n = $urandom_range(0, 9);
            if (n < 7) add_text(fr, $sformatf("%04d", $urandom_range(0, 3)));
            else if (n == 7) add_text(fr, "2147483647");
            else if (n == 8) add_text(fr, "2147483648");
            else add_text(fr, "99999999999999999999");
            add_tail(fr);
        end else if (k < 12) begin
            add_text(fr, "RM");
            fr.push_back(8'("0" + $urandom_range(0, 4)));
            if ($urandom_range(0, 7) == 0) fr.push_back("-");
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                fr.push_back($urandom_range(0, 3) == 0 ? 8'("0" + $urandom_range(0, 9))
                                                        : 8'("0"));
            add_tail(fr);
        end else if (k < 13) begin
            add_text(fr, "EX");
            add_text(fr, $sformatf("%03d", $urandom_range(0, 999)));
            add_tail(fr);
        end else if (k < 15) begin
            add_text(fr, pfx[$urandom_range(0, 4)]);
            add_text(fr, $sformatf("%0d", $urandom_range(0, 9)));
            add_tail(fr);
        end else if (k < 18) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) fr.push_back(8'($urandom_range(0, 255)));
        end else if (k < 19 || $urandom_range(0, 3) != 0) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) fr.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(256, 300);
            for (int i = 0; i < n; i++) fr.push_back(8'($urandom_range(0, 255)));
        end
        queue_frame(fr);
    endtask

    task automatic queue_text(string s);
        byte unsigned fr[$];
        add_text(fr, s);
        queue_frame(fr);
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || i_valid || verdicts_due.size() > 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_interval();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? 24'd0 : (r == 1) ? 24'hFFFFFF : 24'($urandom_range(1, 6000));
    endfunction

    initial begin
        logic [2:0] modes[10] = '{3'd2, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7, 3'd6};
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_valid = 0;
        i_resp_byte = '0;
        i_frame_end = 0;
        i_now_us = '0;
        i_recently_queried = 0;
        i_tuning_active = 0;
        i_last_encoder_us = '0;
        i_ready = 1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        for (int p = 0; p < 10; p++) begin
            write_reg(CFG_AI_MODE, {21'($urandom), modes[p]});
            write_reg(CFG_DISPLAY, {23'($urandom), 1'(p % 2)});
            write_reg(CFG_SM_INT, p == 0 ? 24'd2500 : pick_interval());
            write_reg(CFG_SM_INT_DISP, p == 1 ? 24'hFFFFFF : pick_interval());
            write_reg(CFG_FAIR, p == 0 ? 24'd5000 : pick_interval());
            if (p == 3) write_reg(3'd7, 24'($urandom));
            // The receiver must be ready in at least one slot of the pattern.
            stall_pattern = (p % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            if (p == 0) begin
                // Duplicates, meter parsing corner cases and a too-short frame.
                queue_text("FA00014074000;");
                queue_text("FA00014074000;");
                queue_text("SM00005;");
                queue_text("RM1-012;");
                queue_text("RM20123;");
                queue_text("F");
            end
            for (int n = 0; n < 135; ) begin
                random_frame();
                n = 135 - pending_bytes.size() < n ? 135 : n + 1;
                if (pending_bytes.size() >= 135) n = 135;
            end
            drain();
        end
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
